// File: rtl/core/awsa_pkg.sv
package awsa_pkg;

    localparam int MAX_SIDE  = 4096;
    localparam int FRAC_BITS = 16;

    // fixed field widths
    localparam int COEF_W = 32;
    localparam int IN_W   = 12;
    localparam int CFG_SIDE_W = 13;
    localparam int IDX_W  = 24;
    localparam int CFG_IDX_W = 3;

    // derived widths
    localparam int Q_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W = Q_W + 1;
    localparam int PROD_W = COEF_W + IN_W + 1;
    localparam int LIN_W  = PROD_W + 1;
    localparam int DET_W  = 2 * COEF_W;
    localparam int CST_W  = 2 * COEF_W + 1;
    localparam int K_W    = CST_W + 2;
    localparam int N_W    = ((LIN_W + FRAC_BITS + 1) > K_W ? (LIN_W + FRAC_BITS + 1) : K_W) + 1;
    localparam int DV_W   = DET_W + 1;
    localparam int REM_W  = (DV_W + Q_W) > N_W ? (DV_W + Q_W) : N_W;

    // |det| below 0.001 in units of 2^-(2*FRAC_BITS)
    localparam logic [DET_W-1:0] DET_THR =
        DET_W'(((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000 + 64'd1);

    // pipeline: four front stages, one per quotient bit, output stage
    localparam int NST = Q_W + 5;

    // settle time of the coefficient pipeline after a write
    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] CFG_SETTLE = CNT_W'(5);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_E = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_F = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SRC_W  = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H  = CFG_IDX_W'(7);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             ovf;
        logic             sdiff;
    } div_lane_t;

    // one restoring step: quotient bit at weight 2^sh
    function automatic div_lane_t div_step(input div_lane_t l, input logic [DV_W-1:0] dv,
                                           input int unsigned sh);
        logic [REM_W-1:0] d;
        div_lane_t r;
        d = REM_W'(dv) << sh;
        r = l;
        r.q = {l.q[Q_W-2:0], 1'b0};
        if (l.rem >= d) begin
            r.rem  = l.rem - d;
            r.q[0] = 1'b1;
        end
        return r;
    endfunction

    // source coordinate valid in [0, lim)
    function automatic logic lane_ok(input div_lane_t l, input logic [SIDE_W-1:0] lim);
        logic r;
        if (!l.ovf && l.q == '0) begin
            r = (lim != '0);
        end else begin
            r = !l.ovf && !l.sdiff && ({1'b0, l.q} < lim);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/affine_warp_source_address.sv
// inverse affine warp, nearest neighbour source address
// input channel s_*: one output pixel coordinate (s_out_x, s_out_y) per item
// result channel m_*: source column/row, linear index, inside flag and singular
// flag, one result item per input item, in order
// config channel cfg_*: index 0..5 coef_a..coef_f (signed Q15.16), 6 src_width,
// 7 src_height; cfg_ready is always high, writes are expected only while idle
// throughput: one item per cycle while m_ready is high and no settle is running;
// an item passes 4 front stages, one stage per quotient bit, output register
// the quotient is formed by a 12-step restoring divider, one bit per stage,
// with an overflow compare in the first step for quotients of 4096 and above
// after reset and after any config write, s_ready stays low until the settle counter runs out,
// while the determinant and constant terms settle through their own multiplier stages
// reset clears all valid bits and loads the identity transform and 4096x4096
// when m_ready is low the pipeline compacts its bubbles and then holds; no item
// is dropped or repeated
module affine_warp_source_address
    import awsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0]     cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_W-1:0]       s_out_x,
    input  logic [IN_W-1:0]       s_out_y,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [IN_W-1:0]       m_src_x,
    output logic [IN_W-1:0]       m_src_y,
    output logic [IDX_W-1:0]      m_src_index,
    output logic                  m_inside_res,
    output logic                  m_singular
);

    // config registers
    logic signed [COEF_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg;
    logic signed [COEF_W-1:0] coef_d_reg, coef_e_reg, coef_f_reg;
    logic [CFG_SIDE_W-1:0]    src_width_reg, src_height_reg;
    logic [CNT_W-1:0]         settle_reg;

    // derived coefficient pipeline
    logic signed [DET_W-1:0] pae_reg, pbd_reg, pbf_reg, pce_reg, pcd_reg, paf_reg;
    logic signed [DET_W-1:0] det_reg;
    logic signed [CST_W-1:0] cstx_reg, csty_reg;
    logic signed [K_W-1:0]   kx_reg, ky_reg;
    logic [DET_W-1:0]        detmag_reg;
    logic                    detneg_reg;
    logic [DV_W-1:0]         dv_reg;
    logic                    sing_reg;
    logic [SIDE_W-1:0]       wlim_reg, hlim_reg;

    // item pipeline
    logic [NST-1:0] valid_reg, valid_next, adv;
    logic signed [PROD_W-1:0] ex_reg, by_reg, ay_reg, dx_reg;
    logic signed [LIN_W-1:0]  linx_reg, liny_reg;
    logic signed [N_W-1:0]    nx_reg, ny_reg;
    logic [N_W-1:0]           magx_reg, magy_reg;
    logic                     sdx_reg, sdy_reg;
    div_lane_t                divx_reg [Q_W];
    div_lane_t                divy_reg [Q_W];
    div_lane_t                initx, inity;

    logic [IN_W-1:0]  m_src_x_reg, m_src_y_reg;
    logic [IDX_W-1:0] m_src_index_reg;
    logic             m_inside_reg, m_singular_reg;
    logic             okx, oky;
    logic [IDX_W-1:0] index_calc;

    assign cfg_ready = 1'b1;
    assign s_ready   = adv[0] && (settle_reg == '0);

    // config writes, settle counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg     <= COEF_W'(65536);
            coef_b_reg     <= '0;
            coef_c_reg     <= '0;
            coef_d_reg     <= '0;
            coef_e_reg     <= COEF_W'(65536);
            coef_f_reg     <= '0;
            src_width_reg  <= CFG_SIDE_W'(4096);
            src_height_reg <= CFG_SIDE_W'(4096);
            settle_reg     <= CFG_SETTLE;
        end else begin
            if (cfg_valid && cfg_ready) begin
                settle_reg <= CFG_SETTLE;
                unique case (cfg_index)
                    REG_COEF_A: coef_a_reg <= cfg_data;
                    REG_COEF_B: coef_b_reg <= cfg_data;
                    REG_COEF_C: coef_c_reg <= cfg_data;
                    REG_COEF_D: coef_d_reg <= cfg_data;
                    REG_COEF_E: coef_e_reg <= cfg_data;
                    REG_COEF_F: coef_f_reg <= cfg_data;
                    REG_SRC_W:  src_width_reg  <= cfg_data[CFG_SIDE_W-1:0];
                    REG_SRC_H:  src_height_reg <= cfg_data[CFG_SIDE_W-1:0];
                endcase
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - CNT_W'(1);
            end
        end
    end

    // determinant and constant terms, four register stages
    always_ff @(posedge aclk) begin
        // products
        pae_reg <= coef_a_reg * coef_e_reg;
        pbd_reg <= coef_b_reg * coef_d_reg;
        pbf_reg <= coef_b_reg * coef_f_reg;
        pce_reg <= coef_c_reg * coef_e_reg;
        pcd_reg <= coef_c_reg * coef_d_reg;
        paf_reg <= coef_a_reg * coef_f_reg;
        // det and numerator constants
        det_reg  <= pae_reg - pbd_reg;
        cstx_reg <= CST_W'(pbf_reg) - CST_W'(pce_reg);
        csty_reg <= CST_W'(pcd_reg) - CST_W'(paf_reg);
        // doubled constant plus det folds in the half-pixel offset
        kx_reg     <= (K_W'(cstx_reg) <<< 1) + K_W'(det_reg);
        ky_reg     <= (K_W'(csty_reg) <<< 1) + K_W'(det_reg);
        detmag_reg <= det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        detneg_reg <= det_reg[DET_W-1];
        // divisor and singular check
        dv_reg   <= {detmag_reg, 1'b0};
        sing_reg <= detmag_reg < DET_THR;
        // clipped image size
        wlim_reg <= (src_width_reg > CFG_SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                            : SIDE_W'(src_width_reg);
        hlim_reg <= (src_height_reg > CFG_SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                             : SIDE_W'(src_height_reg);
    end

    // a stage moves when it is empty or the next one moves
    always_comb begin
        adv[NST-1] = !valid_reg[NST-1] || m_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
        valid_next[0] = adv[0] ? (s_valid && s_ready) : valid_reg[0];
        for (int s = 1; s < NST; s++) begin
            valid_next[s] = adv[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // front stages: products, linear terms, numerator, magnitude
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ex_reg <= coef_e_reg * $signed({1'b0, s_out_x});
            by_reg <= coef_b_reg * $signed({1'b0, s_out_y});
            ay_reg <= coef_a_reg * $signed({1'b0, s_out_y});
            dx_reg <= coef_d_reg * $signed({1'b0, s_out_x});
        end
        if (adv[1]) begin
            linx_reg <= LIN_W'(ex_reg) - LIN_W'(by_reg);
            liny_reg <= LIN_W'(ay_reg) - LIN_W'(dx_reg);
        end
        if (adv[2]) begin
            nx_reg <= (N_W'(linx_reg) <<< (FRAC_BITS + 1)) + N_W'(kx_reg);
            ny_reg <= (N_W'(liny_reg) <<< (FRAC_BITS + 1)) + N_W'(ky_reg);
        end
        if (adv[3]) begin
            magx_reg <= nx_reg[N_W-1] ? N_W'(-nx_reg) : N_W'(nx_reg);
            magy_reg <= ny_reg[N_W-1] ? N_W'(-ny_reg) : N_W'(ny_reg);
            sdx_reg  <= nx_reg[N_W-1] ^ detneg_reg;
            sdy_reg  <= ny_reg[N_W-1] ^ detneg_reg;
        end
    end

    // first divider step also flags quotients past the largest side
    always_comb begin
        initx.rem   = REM_W'(magx_reg);
        initx.q     = '0;
        initx.ovf   = REM_W'(magx_reg) >= (REM_W'(dv_reg) << Q_W);
        initx.sdiff = sdx_reg;
        inity.rem   = REM_W'(magy_reg);
        inity.q     = '0;
        inity.ovf   = REM_W'(magy_reg) >= (REM_W'(dv_reg) << Q_W);
        inity.sdiff = sdy_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            divx_reg[0] <= div_step(initx, dv_reg, Q_W - 1);
            divy_reg[0] <= div_step(inity, dv_reg, Q_W - 1);
        end
    end

    for (genvar k = 1; k < Q_W; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv[4 + k]) begin
                divx_reg[k] <= div_step(divx_reg[k-1], dv_reg, Q_W - 1 - k);
                divy_reg[k] <= div_step(divy_reg[k-1], dv_reg, Q_W - 1 - k);
            end
        end
    end

    // range checks and linear index
    always_comb begin
        okx = lane_ok(divx_reg[Q_W-1], wlim_reg);
        oky = lane_ok(divy_reg[Q_W-1], hlim_reg);
        index_calc = IDX_W'(divy_reg[Q_W-1].q * wlim_reg) + IDX_W'(divx_reg[Q_W-1].q);
    end

    always_ff @(posedge aclk) begin
        if (adv[NST-1]) begin
            m_singular_reg <= sing_reg;
            if (!sing_reg && okx && oky) begin
                m_src_x_reg     <= IN_W'(divx_reg[Q_W-1].q);
                m_src_y_reg     <= IN_W'(divy_reg[Q_W-1].q);
                m_src_index_reg <= index_calc;
                m_inside_reg    <= 1'b1;
            end else begin
                m_src_x_reg     <= '0;
                m_src_y_reg     <= '0;
                m_src_index_reg <= '0;
                m_inside_reg    <= 1'b0;
            end
        end
    end

    assign m_valid      = valid_reg[NST-1];
    assign m_src_x      = m_src_x_reg;
    assign m_src_y      = m_src_y_reg;
    assign m_src_index  = m_src_index_reg;
    assign m_inside_res = m_inside_reg;
    assign m_singular   = m_singular_reg;

    // singular results carry no mapping
    a_sing_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> !m_inside_res && m_src_index == '0 && m_src_x == '0)
        else $error("singular result with mapping");

    // inside results lie in the clipped image
    a_inside_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_inside_res |-> ({1'b0, m_src_x} < wlim_reg) && ({1'b0, m_src_y} < hlim_reg))
        else $error("inside result out of image");

    // no item taken while the coefficient pipeline settles
    a_settle_block: assert property (@(posedge aclk) disable iff (!aresetn)
        settle_reg != '0 |-> !s_ready)
        else $error("item accepted during settle");

    // a stalled output stage keeps its item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_src_index) && $stable(m_inside_res))
        else $error("output changed under stall");

endmodule
